>>> design/pdts_pkg.sv
// Shared types, constants and lookup functions of the photon direction and time sampler.
package pdts_pkg;

  localparam int DIRECTION_BINS    = 834;
  localparam int TIME_BINS         = 111;
  localparam int TIME_ANGLE_GROUPS = 52;
  localparam int TIME_ENTRIES      = TIME_BINS * TIME_ANGLE_GROUPS;
  localparam int DIR_AW            = $clog2(DIRECTION_BINS);
  localparam int TIME_AW           = $clog2(TIME_ENTRIES);
  localparam int THETA_RINGS       = 47;

  // Command codes
  localparam logic [1:0] CMD_DIR_WRITE  = 2'd0;
  localparam logic [1:0] CMD_TIME_WRITE = 2'd1;
  localparam logic [1:0] CMD_SAMPLE     = 2'd2;

  // Fixed-point constants
  localparam logic [32:0] ONE_Q32     = 33'h1_0000_0000;
  localparam logic [31:0] LN2_Q32     = 32'd2977044472;
  localparam logic [31:0] INV_E_Q32   = 32'd1580030169;
  localparam logic [26:0] DEG_TO_RAD  = 27'd74961321;
  localparam logic [31:0] TWO_PI_Q29  = 32'd3373259426;
  localparam logic [32:0] VALID_MIN   = 33'd4290672329;
  localparam logic [31:0] SLOPE_MIN   = 32'd17;
  localparam logic [63:0] DM_LIMIT    = 64'h02BC_0000_0000_0000;
  localparam logic [32:0] DEG180_Q24  = 33'd3019898880;
  localparam logic [31:0] DEG90_Q24   = 32'd1509949440;
  localparam logic [31:0] DEG45_Q24   = 32'd754974720;
  localparam logic [16:0] THETA_SCALE = 17'd100000;
  localparam logic [31:0] HALF_Q32    = 32'h8000_0000;
  localparam logic [15:0] EXP_ZERO_M  = 16'd23;
  localparam logic [3:0]  EXP_TERMS   = 4'd13;
  localparam logic [3:0]  LN_TERMS    = 4'd11;
  localparam logic [3:0]  TRIG_TERMS  = 4'd8;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [12:0]        entry_index;
    logic [32:0]        cumulative_value;
    logic signed [31:0] slope_theta;
    logic signed [31:0] slope_phi;
    logic [31:0]        rand_direction;
    logic [31:0]        rand_theta;
    logic [31:0]        rand_phi;
    logic [31:0]        rand_time_bin;
    logic [31:0]        rand_time_offset;
    logic [31:0]        rand_flip;
  } in_word_t;

  typedef struct packed {
    logic               status;
    logic signed [19:0] time_value;
    logic signed [31:0] cos_theta;
    logic [31:0]        phi_angle;
  } out_word_t;

  typedef struct packed {
    logic [31:0] slope_phi;
    logic [31:0] slope_theta;
    logic [32:0] cdf;
  } dir_entry_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_DREAD, ST_DCHK, ST_RING, ST_PLO_M, ST_PLO_D, ST_PHI_M, ST_PHI_D,
    ST_BOUNDS_END, ST_DRAW, ST_UNI_M, ST_UNI_R, ST_A_M, ST_A_R, ST_E_M, ST_E_D,
    ST_E_ACC, ST_E_FIN, ST_E_INV_M, ST_E_INV_R, ST_MQ_M, ST_MQ_R, ST_V, ST_L_NORM,
    ST_L_Z, ST_L_Z2, ST_L_DIV, ST_L_ACC, ST_L_T, ST_L_G, ST_OFF_R, ST_DEND,
    ST_DFIN, ST_TG_M, ST_TG, ST_TH_SRCH, ST_PH_SRCH, ST_TREAD, ST_TCHK, ST_T_M1,
    ST_T_M2, ST_T_R, ST_RAD_M, ST_RAD_R, ST_COS_M, ST_COS_R, ST_C_SQ, ST_C_INIT,
    ST_C_M, ST_C_D, ST_C_ACC, ST_C_END, ST_DIV, ST_DONE
  } state_t;

  // Phi bins per theta ring
  function automatic logic [4:0] ring_phis(input logic [5:0] r);
    logic [4:0] n;
    unique case (r)
      6'd0:    n = 5'd3;
      6'd1:    n = 5'd7;
      6'd2:    n = 5'd10;
      6'd3:    n = 5'd13;
      6'd4:    n = 5'd16;
      6'd5:    n = 5'd19;
      6'd41:   n = 5'd18;
      6'd42:   n = 5'd15;
      6'd43:   n = 5'd13;
      6'd44:   n = 5'd10;
      6'd45:   n = 5'd7;
      6'd46:   n = 5'd3;
      default: n = 5'd20;
    endcase
    return n;
  endfunction

  // Theta group edges in units of 1e-5 degree
  function automatic logic [24:0] theta_edge(input logic [4:0] i);
    logic [24:0] e;
    unique case (i)
      5'd0:    e = 25'd443924;
      5'd1:    e = 25'd627957;
      5'd2:    e = 25'd810961;
      5'd3:    e = 25'd993636;
      5'd4:    e = 25'd1147830;
      5'd5:    e = 25'd1406990;
      5'd6:    e = 25'd1819490;
      5'd7:    e = 25'd2233160;
      5'd8:    e = 25'd2584190;
      5'd9:    e = 25'd3686990;
      5'd10:   e = 25'd4557300;
      5'd11:   e = 25'd5313010;
      5'd12:   e = 25'd6325630;
      5'd13:   e = 25'd9000000;
      5'd14:   e = 25'd11357800;
      5'd15:   e = 25'd14313000;
      default: e = 25'd18000000;
    endcase
    return e;
  endfunction

  // Phi group edges in degrees
  function automatic logic [7:0] phi_edge(input logic [5:0] i);
    logic [7:0] e;
    unique case (i)
      6'd0: e = 8'd55;   6'd1: e = 8'd105;  6'd2: e = 8'd180;  6'd3: e = 8'd45;
      6'd4: e = 8'd110;  6'd5: e = 8'd180;  6'd6: e = 8'd45;   6'd7: e = 8'd110;
      6'd8: e = 8'd180;  6'd9: e = 8'd45;   6'd10: e = 8'd95;  6'd11: e = 8'd180;
      6'd12: e = 8'd45;  6'd13: e = 8'd120; 6'd14: e = 8'd180; 6'd15: e = 8'd45;
      6'd16: e = 8'd110; 6'd17: e = 8'd180; 6'd18: e = 8'd40;  6'd19: e = 8'd75;
      6'd20: e = 8'd180; 6'd21: e = 8'd30;  6'd22: e = 8'd45;  6'd23: e = 8'd95;
      6'd24: e = 8'd180; 6'd25: e = 8'd40;  6'd26: e = 8'd75;  6'd27: e = 8'd110;
      6'd28: e = 8'd180; 6'd29: e = 8'd30;  6'd30: e = 8'd45;  6'd31: e = 8'd85;
      6'd32: e = 8'd145; 6'd33: e = 8'd180; 6'd34: e = 8'd40;  6'd35: e = 8'd75;
      6'd36: e = 8'd115; 6'd37: e = 8'd180; 6'd38: e = 8'd40;  6'd39: e = 8'd95;
      6'd40: e = 8'd180; 6'd41: e = 8'd45;  6'd42: e = 8'd85;  6'd43: e = 8'd180;
      6'd44: e = 8'd40;  6'd45: e = 8'd110; 6'd46: e = 8'd180; 6'd47: e = 8'd65;
      6'd48: e = 8'd120; default: e = 8'd180;
    endcase
    return e;
  endfunction

  // First phi group of each theta group
  function automatic logic [5:0] group_start(input logic [4:0] i);
    logic [5:0] g;
    unique case (i)
      5'd0: g = 6'd0;   5'd1: g = 6'd3;   5'd2: g = 6'd6;   5'd3: g = 6'd9;
      5'd4: g = 6'd12;  5'd5: g = 6'd15;  5'd6: g = 6'd18;  5'd7: g = 6'd21;
      5'd8: g = 6'd25;  5'd9: g = 6'd29;  5'd10: g = 6'd34; 5'd11: g = 6'd38;
      5'd12: g = 6'd41; 5'd13: g = 6'd44; 5'd14: g = 6'd47; 5'd15: g = 6'd50;
      5'd16: g = 6'd51; default: g = 6'd52;
    endcase
    return g;
  endfunction

  // Time segment of a time bin
  function automatic logic [2:0] seg_of(input logic [6:0] tb);
    logic [2:0] s;
    if (tb >= 7'd106)      s = 3'd5;
    else if (tb >= 7'd90)  s = 3'd4;
    else if (tb >= 7'd80)  s = 3'd3;
    else if (tb >= 7'd60)  s = 3'd2;
    else if (tb >= 7'd40)  s = 3'd1;
    else                   s = 3'd0;
    return s;
  endfunction

  function automatic logic [6:0] seg_start(input logic [2:0] s);
    logic [6:0] v;
    unique case (s)
      3'd1:    v = 7'd40;
      3'd2:    v = 7'd60;
      3'd3:    v = 7'd80;
      3'd4:    v = 7'd90;
      3'd5:    v = 7'd106;
      default: v = 7'd0;
    endcase
    return v;
  endfunction

  function automatic logic [19:0] seg_base(input logic [2:0] s);
    logic [19:0] v;
    unique case (s)
      3'd1:    v = 20'd2560;
      3'd2:    v = 20'd7680;
      3'd3:    v = 20'd23040;
      3'd4:    v = 20'd51200;
      3'd5:    v = 20'd256000;
      default: v = 20'hFF600;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] seg_width(input logic [2:0] s);
    logic [15:0] v;
    unique case (s)
      3'd1:    v = 16'd256;
      3'd2:    v = 16'd768;
      3'd3:    v = 16'd2816;
      3'd4:    v = 16'd12800;
      3'd5:    v = 16'd51200;
      default: v = 16'd128;
    endcase
    return v;
  endfunction

  // Taylor divisor of term k for sine or cosine
  function automatic logic [8:0] trig_div(input logic [3:0] k, input logic want_sin);
    logic [8:0] two_k;
    two_k = {4'b0, k, 1'b0};
    return want_sin ? 9'(two_k * (two_k + 9'd1)) : 9'((two_k - 9'd1) * two_k);
  endfunction

endpackage

>>> design/photon_direction_time_sampler.sv
// Photon direction and time sampler: table memories, search and shared arithmetic sequencer.
//
// Usage: words on the req channel either load the direction table (cdf plus theta
// and phi slopes per bin), load the time table (group*111+bin), or ask for one
// sample with six uniform randoms. Each sample word gives exactly one rsp word:
// cos(theta), phi and time, or status 1 when the direction table is not valid.
// Load words and out-of-range indexes give no rsp word.
// A sample scans each table memory entry by entry (up to 834 direction and
// 111 time entries) and runs its divisions in the shared restoring divider,
// which serves the bin bounds, the exp and ln series and the cosine series
// (up to 64 divisions per sample). A sample on an invalid table goes straight
// to its rsp word with status 1.
// One word is in work at a time; req_stall is high while a sample is computed.
// The rsp word sits in an output register; a stalled rsp holds its word and the
// next finished sample waits for it; loads are taken only while no sample is in work.
// Reset clears the table-valid flag and all control; table contents are not
// cleared and must be written before use.
module photon_direction_time_sampler (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  pdts_pkg::in_word_t  req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output pdts_pkg::out_word_t rsp
);
  import pdts_pkg::*;

  // Table memories
  dir_entry_t  dir_mem [DIRECTION_BINS];
  logic [32:0] time_mem [TIME_ENTRIES];
  dir_entry_t  dir_q;
  logic [32:0] time_q;

  state_t state, state_next, div_ret;
  logic   dist_valid;
  logic   req_fire;

  // Latched randoms
  logic [31:0] rnd_dir, rnd_th, rnd_ph, rnd_tb, rnd_to, rnd_flip;

  // Direction bin and bounds
  logic [DIR_AW-1:0] cnt;
  logic [31:0] th_slope, ph_slope;
  logic [5:0]  ring;
  logic [DIR_AW-1:0] rsub;
  logic [4:0]  nphi;
  logic [7:0]  tdeg, tdeg_hi;
  logic [31:0] tlo, thi, plo, phigh;

  // In-bin draw
  logic        which;
  logic [31:0] d_lo, d_hi, d_w, d_mag, d_u;
  logic        d_neg;
  logic [31:0] cur_slope, cur_mag;
  logic [4:0]  ea_m;
  logic [31:0] ea_f;
  logic [32:0] term, e_r, v, lm;
  logic signed [35:0] acc;
  logic [3:0]  kc;
  logic [4:0]  lk;
  logic [31:0] z2, off, dres, theta, phi;
  logic [33:0] sum;
  logic [32:0] q_val, uu, mq;
  logic [63:0] a_val;
  logic [37:0] g_val;

  // Groups and time
  logic [48:0] tt;
  logic [4:0]  ith;
  logic [5:0]  iph;
  logic [TIME_AW-1:0] tbase, taddr;
  logic [6:0]  tb;
  logic [2:0]  seg;
  logic [19:0] tr1, tv;
  logic [31:0] rad, rad_raw;

  // Cosine
  logic [31:0] t_fold, c_arg, c_r, c_r2, cos_out, c4;
  logic        fold_neg, fold_sin, c_neg, c_sin;
  logic [32:0] cpos;
  logic        res_status;

  // Shared multiplier and divider
  logic [32:0] mul_a, mul_b;
  logic [65:0] prod;
  logic [63:0] dvd;
  logic [33:0] den, rem;
  logic [34:0] rem_sh;
  logic [5:0]  dcnt;

  // Output register
  out_word_t rsp_q;
  logic      rsp_v;

  assign req_stall = (state != ST_IDLE);
  assign req_fire  = req_valid && !req_stall;
  assign rsp_valid = rsp_v;
  assign rsp       = rsp_q;

  // Write and read the direction table
  always_ff @(posedge clk) begin
    if (req_fire && req.cmd == CMD_DIR_WRITE &&
        req.entry_index < 13'(DIRECTION_BINS)) begin
      dir_mem[req.entry_index[DIR_AW-1:0]] <= '{slope_phi: req.slope_phi,
                                                slope_theta: req.slope_theta,
                                                cdf: req.cumulative_value};
    end
    dir_q <= dir_mem[cnt];
  end

  // Write and read the time table
  assign taddr = tbase + TIME_AW'(tb);
  always_ff @(posedge clk) begin
    if (req_fire && req.cmd == CMD_TIME_WRITE &&
        req.entry_index < 13'(TIME_ENTRIES)) begin
      time_mem[req.entry_index] <= req.cumulative_value;
    end
    time_q <= time_mem[taddr];
  end

  // Derived values used by several states
  always_comb begin
    nphi      = ring_phis(ring);
    tdeg      = (ring < 6'd34) ? 8'(ring * 6'd3) : 8'(8'(ring) * 8'd6 - 8'd102);
    tdeg_hi   = (ring < 6'd34) ? tdeg + 8'd3 : tdeg + 8'd6;
    cur_slope = which ? ph_slope : th_slope;
    cur_mag   = cur_slope[31] ? 32'(0 - cur_slope) : cur_slope;
    q_val     = ONE_Q32 - e_r;
    uu        = d_neg ? {1'b0, d_u} : ONE_Q32 - {1'b0, d_u};
    mq        = uu[32] ? q_val : prod[64:32];
    a_val     = prod[63:0];
    g_val     = 38'(lk) * 38'(LN2_Q32) + {3'b0, sum, 1'b0};
    seg       = seg_of(tb);
    rad_raw   = prod[58:27];
    fold_neg  = theta > DEG90_Q24;
    t_fold    = fold_neg ? ((theta > DEG180_Q24[31:0]) ? 32'd0 : DEG180_Q24[31:0] - theta)
                         : theta;
    fold_sin  = t_fold > DEG45_Q24;
    c_arg     = fold_sin ? DEG90_Q24 - t_fold : t_fold;
    cpos      = acc[35] ? 33'd0 : acc[32:0];
    c4        = 32'((34'(cpos) + 34'd2) >> 2);
    rem_sh    = {rem, dvd[63]};
  end

  // Select multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_PLO_M:   begin mul_a = DEG180_Q24; mul_b = 33'(rsub); end
      ST_PHI_M:   begin mul_a = DEG180_Q24; mul_b = 33'(rsub) + 33'd1; end
      ST_UNI_M:   begin mul_a = {1'b0, d_u}; mul_b = {1'b0, d_w}; end
      ST_A_M:     begin mul_a = {1'b0, d_mag}; mul_b = {1'b0, d_w}; end
      ST_E_M:     begin mul_a = term; mul_b = {1'b0, ea_f}; end
      ST_E_INV_M: begin mul_a = e_r; mul_b = 33'(INV_E_Q32); end
      ST_MQ_M:    begin mul_a = uu; mul_b = q_val; end
      ST_L_Z:     begin mul_a = {1'b0, dvd[31:0]}; mul_b = {1'b0, dvd[31:0]}; end
      ST_L_ACC:   begin mul_a = term; mul_b = {1'b0, z2}; end
      ST_TG_M:    begin mul_a = {1'b0, theta}; mul_b = 33'(THETA_SCALE); end
      ST_T_M1:    begin mul_a = 33'(tb - seg_start(seg)); mul_b = 33'(seg_width(seg)); end
      ST_T_M2:    begin mul_a = {1'b0, rnd_to}; mul_b = 33'(seg_width(seg)); end
      ST_RAD_M:   begin mul_a = {1'b0, phi}; mul_b = 33'(DEG_TO_RAD); end
      ST_COS_M:   begin mul_a = {1'b0, c_arg}; mul_b = 33'(DEG_TO_RAD); end
      ST_C_SQ:    begin mul_a = {1'b0, c_r}; mul_b = {1'b0, c_r}; end
      ST_C_M:     begin mul_a = term; mul_b = {1'b0, c_r2}; end
      default:    begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Register each product
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_fire && req.cmd == CMD_SAMPLE) state_next = dist_valid ? ST_DREAD : ST_DONE;
      end
      ST_DREAD: state_next = ST_DCHK;
      ST_DCHK: begin
        if ({1'b0, rnd_dir} < dir_q.cdf || cnt == DIR_AW'(DIRECTION_BINS - 1))
          state_next = ST_RING;
        else
          state_next = ST_DREAD;
      end
      ST_RING: begin
        if (!(ring < 6'(THETA_RINGS - 1) && rsub >= DIR_AW'(nphi))) state_next = ST_PLO_M;
      end
      ST_PLO_M:      state_next = ST_PLO_D;
      ST_PLO_D:      state_next = ST_DIV;
      ST_PHI_M:      state_next = ST_PHI_D;
      ST_PHI_D:      state_next = ST_DIV;
      ST_BOUNDS_END: state_next = ST_DRAW;
      ST_DRAW:       state_next = (cur_mag < SLOPE_MIN) ? ST_UNI_M : ST_A_M;
      ST_UNI_M:      state_next = ST_UNI_R;
      ST_UNI_R:      state_next = ST_DFIN;
      ST_A_M:        state_next = ST_A_R;
      ST_A_R: begin
        if (!d_neg && a_val >= DM_LIMIT)          state_next = ST_V;
        else if (a_val[63:48] >= EXP_ZERO_M)      state_next = ST_MQ_M;
        else                                      state_next = ST_E_M;
      end
      ST_E_M:     state_next = ST_E_D;
      ST_E_D:     state_next = ST_DIV;
      ST_E_ACC:   state_next = (kc == EXP_TERMS) ? ST_E_FIN : ST_E_M;
      ST_E_FIN:   state_next = (ea_m == 5'd0) ? ST_MQ_M : ST_E_INV_M;
      ST_E_INV_M: state_next = ST_E_INV_R;
      ST_E_INV_R: state_next = (ea_m == 5'd1) ? ST_MQ_M : ST_E_INV_M;
      ST_MQ_M:    state_next = ST_MQ_R;
      ST_MQ_R:    state_next = ST_V;
      ST_V:       state_next = (v == 33'd0) ? ST_DEND : ST_L_NORM;
      ST_L_NORM:  state_next = (lm < 33'(HALF_Q32)) ? ST_L_NORM : ST_DIV;
      ST_L_Z:     state_next = ST_L_Z2;
      ST_L_Z2:    state_next = ST_L_DIV;
      ST_L_DIV:   state_next = ST_DIV;
      ST_L_ACC:   state_next = ST_L_T;
      ST_L_T:     state_next = (kc == LN_TERMS) ? ST_L_G : ST_L_DIV;
      ST_L_G:     state_next = ST_DIV;
      ST_OFF_R:   state_next = ST_DEND;
      ST_DEND:    state_next = ST_DFIN;
      ST_DFIN:    state_next = which ? ST_TG_M : ST_DRAW;
      ST_TG_M:    state_next = ST_TG;
      ST_TG:      state_next = ST_TH_SRCH;
      ST_TH_SRCH: begin
        if (!(ith < 5'd16 && tt >= {theta_edge(ith), 24'b0})) state_next = ST_PH_SRCH;
      end
      ST_PH_SRCH: begin
        if (!(iph < group_start(ith + 5'd1) - 6'd1 && phi >= {phi_edge(iph), 24'b0}))
          state_next = ST_TREAD;
      end
      ST_TREAD:   state_next = ST_TCHK;
      ST_TCHK: begin
        if ({1'b0, rnd_tb} < time_q || tb == 7'(TIME_BINS - 1)) state_next = ST_T_M1;
        else                                                   state_next = ST_TREAD;
      end
      ST_T_M1:    state_next = ST_T_M2;
      ST_T_M2:    state_next = ST_T_R;
      ST_T_R:     state_next = ST_RAD_M;
      ST_RAD_M:   state_next = ST_RAD_R;
      ST_RAD_R:   state_next = ST_COS_M;
      ST_COS_M:   state_next = ST_COS_R;
      ST_COS_R:   state_next = ST_C_SQ;
      ST_C_SQ:    state_next = ST_C_INIT;
      ST_C_INIT:  state_next = ST_C_M;
      ST_C_M:     state_next = ST_C_D;
      ST_C_D:     state_next = ST_DIV;
      ST_C_ACC:   state_next = (kc == TRIG_TERMS) ? ST_C_END : ST_C_M;
      ST_C_END:   state_next = ST_DONE;
      ST_DIV:     state_next = (dcnt == 6'd63) ? div_ret : ST_DIV;
      ST_DONE:    state_next = (!rsp_v || !rsp_stall) ? ST_IDLE : ST_DONE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      dist_valid <= 1'b0;
      rsp_v      <= 1'b0;
    end else begin
      state <= state_next;
      if (req_fire && req.cmd == CMD_DIR_WRITE &&
          req.entry_index == 13'(DIRECTION_BINS - 1)) begin
        dist_valid <= req.cumulative_value >= VALID_MIN;
      end
      // Load a finished word, drop a taken one
      if (state == ST_DONE && (!rsp_v || !rsp_stall)) rsp_v <= 1'b1;
      else if (rsp_v && !rsp_stall)                   rsp_v <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (req_fire && req.cmd == CMD_SAMPLE) begin
          rnd_dir    <= req.rand_direction;
          rnd_th     <= req.rand_theta;
          rnd_ph     <= req.rand_phi;
          rnd_tb     <= req.rand_time_bin;
          rnd_to     <= req.rand_time_offset;
          rnd_flip   <= req.rand_flip;
          cnt        <= '0;
          res_status <= !dist_valid;
          tv         <= '0;
          cos_out    <= '0;
          rad        <= '0;
        end
      end
      ST_DCHK: begin
        if ({1'b0, rnd_dir} < dir_q.cdf || cnt == DIR_AW'(DIRECTION_BINS - 1)) begin
          th_slope <= dir_q.slope_theta;
          ph_slope <= dir_q.slope_phi;
          rsub     <= cnt;
          ring     <= '0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
      // Walk the theta rings to split the bin index
      ST_RING: begin
        if (ring < 6'(THETA_RINGS - 1) && rsub >= DIR_AW'(nphi)) begin
          rsub <= rsub - DIR_AW'(nphi);
          ring <= ring + 6'd1;
        end else begin
          tlo <= {tdeg, 24'b0};
          thi <= {tdeg_hi, 24'b0};
          if (rsub >= DIR_AW'(nphi)) rsub <= DIR_AW'(nphi) - 1'b1;
        end
      end
      ST_PLO_D: begin
        dvd <= prod[63:0]; den <= 34'(nphi); rem <= '0; dcnt <= '0; div_ret <= ST_PHI_M;
      end
      ST_PHI_M: plo <= dvd[31:0];
      ST_PHI_D: begin
        dvd <= prod[63:0]; den <= 34'(nphi); rem <= '0; dcnt <= '0;
        div_ret <= ST_BOUNDS_END;
      end
      ST_BOUNDS_END: begin
        phigh <= dvd[31:0];
        which <= 1'b0;
      end
      ST_DRAW: begin
        d_lo  <= which ? plo : tlo;
        d_hi  <= which ? phigh : thi;
        d_w   <= which ? phigh - plo : thi - tlo;
        d_neg <= cur_slope[31];
        d_mag <= cur_mag;
        d_u   <= which ? rnd_ph : rnd_th;
      end
      ST_UNI_R: dres <= d_lo + prod[63:32];
      ST_A_R: begin
        if (!d_neg && a_val >= DM_LIMIT) begin
          v <= {1'b0, d_u};
        end else if (a_val[63:48] >= EXP_ZERO_M) begin
          e_r <= '0;
        end else begin
          ea_m <= a_val[52:48];
          ea_f <= a_val[47:16];
          term <= ONE_Q32;
          acc  <= 36'(ONE_Q32);
          kc   <= 4'd1;
        end
      end
      ST_E_D: begin
        dvd <= {31'b0, prod[64:32]}; den <= 34'(kc); rem <= '0; dcnt <= '0;
        div_ret <= ST_E_ACC;
      end
      ST_E_ACC: begin
        term <= dvd[32:0];
        acc  <= kc[0] ? acc - $signed({3'b0, dvd[32:0]}) : acc + $signed({3'b0, dvd[32:0]});
        kc   <= kc + 4'd1;
      end
      ST_E_FIN: e_r <= cpos;
      ST_E_INV_R: begin
        e_r  <= prod[64:32];
        ea_m <= ea_m - 5'd1;
      end
      ST_MQ_R: v <= ONE_Q32 - mq;
      ST_V: begin
        if (v == 33'd0) begin
          off <= d_w;
        end else begin
          lm <= v;
          lk <= '0;
        end
      end
      // Normalize into [1/2, 1], then start the atanh argument division
      ST_L_NORM: begin
        if (lm < 33'(HALF_Q32)) begin
          lm <= {lm[31:0], 1'b0};
          lk <= lk + 5'd1;
        end else begin
          dvd     <= {32'(ONE_Q32 - lm), 32'b0};
          den     <= 34'(ONE_Q32) + 34'(lm);
          rem     <= '0;
          dcnt    <= '0;
          div_ret <= ST_L_Z;
        end
      end
      ST_L_Z2: begin
        z2   <= prod[63:32];
        term <= {1'b0, dvd[31:0]};
        sum  <= '0;
        kc   <= '0;
      end
      ST_L_DIV: begin
        dvd <= {31'b0, term}; den <= 34'({kc, 1'b1}); rem <= '0; dcnt <= '0;
        div_ret <= ST_L_ACC;
      end
      ST_L_ACC: sum <= sum + 34'(dvd[32:0]);
      ST_L_T: begin
        term <= prod[64:32];
        kc   <= kc + 4'd1;
      end
      ST_L_G: begin
        dvd <= {10'b0, g_val, 16'b0}; den <= 34'(d_mag); rem <= '0; dcnt <= '0;
        div_ret <= ST_OFF_R;
      end
      ST_OFF_R: off <= (dvd > 64'(d_w)) ? d_w : dvd[31:0];
      ST_DEND:  dres <= d_neg ? d_lo + off : d_hi - off;
      ST_DFIN: begin
        if (which) phi <= dres;
        else       theta <= dres;
        which <= 1'b1;
      end
      ST_TG: begin
        tt  <= prod[48:0];
        ith <= '0;
      end
      // Find theta group, then phi group
      ST_TH_SRCH: begin
        if (ith < 5'd16 && tt >= {theta_edge(ith), 24'b0}) ith <= ith + 5'd1;
        else                                               iph <= group_start(ith);
      end
      ST_PH_SRCH: begin
        if (iph < group_start(ith + 5'd1) - 6'd1 && phi >= {phi_edge(iph), 24'b0}) begin
          iph <= iph + 6'd1;
        end else begin
          tbase <= TIME_AW'(TIME_AW'(iph) * TIME_AW'(TIME_BINS));
          tb    <= '0;
        end
      end
      ST_TCHK: begin
        if (!({1'b0, rnd_tb} < time_q || tb == 7'(TIME_BINS - 1))) tb <= tb + 7'd1;
      end
      ST_T_M2: tr1 <= prod[19:0];
      ST_T_R:  tv  <= seg_base(seg) + tr1 + {4'b0, prod[47:32]};
      ST_RAD_R: rad <= (rnd_flip < HALF_Q32) ? TWO_PI_Q29 - rad_raw : rad_raw;
      ST_COS_M: begin
        c_neg <= fold_neg;
        c_sin <= fold_sin;
      end
      ST_COS_R: c_r <= prod[55:24];
      ST_C_INIT: begin
        c_r2 <= prod[63:32];
        term <= c_sin ? {1'b0, c_r} : ONE_Q32;
        acc  <= c_sin ? 36'(c_r) : 36'(ONE_Q32);
        kc   <= 4'd1;
      end
      ST_C_D: begin
        dvd <= {31'b0, prod[64:32]}; den <= 34'(trig_div(kc, c_sin)); rem <= '0;
        dcnt <= '0; div_ret <= ST_C_ACC;
      end
      ST_C_ACC: begin
        term <= dvd[32:0];
        acc  <= kc[0] ? acc - $signed({3'b0, dvd[32:0]}) : acc + $signed({3'b0, dvd[32:0]});
        kc   <= kc + 4'd1;
      end
      ST_C_END: cos_out <= c_neg ? 32'(0 - c4) : c4;
      // One restoring quotient bit per cycle
      ST_DIV: begin
        if (rem_sh >= {1'b0, den}) begin
          rem <= 34'(rem_sh - {1'b0, den});
          dvd <= {dvd[62:0], 1'b1};
        end else begin
          rem <= rem_sh[33:0];
          dvd <= {dvd[62:0], 1'b0};
        end
        dcnt <= dcnt + 6'd1;
      end
      ST_DONE: begin
        if (!rsp_v || !rsp_stall) begin
          rsp_q.status     <= res_status;
          rsp_q.time_value <= $signed(tv);
          rsp_q.cos_theta  <= $signed(cos_out);
          rsp_q.phi_angle  <= rad;
        end
      end
      default: begin
      end
    endcase
  end

  // A sample on an invalid table goes straight to the result with an error
  a_invalid_sample: assert property (@(posedge clk) disable iff (rst)
    req_fire && req.cmd == CMD_SAMPLE && !dist_valid |=> state == ST_DONE && res_status)
    else $error("invalid-table sample did not report an error");

  // The divider never runs on a zero divisor
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> den != '0)
    else $error("division by zero");

  // A result word is only loaded from the final state
  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_v) |-> $past(state) == ST_DONE)
    else $error("result word loaded outside the final state");

endmodule
